[hw/rtl/mte_pkg.sv]
`timescale 1ns / 1ps

package mte_pkg;

    localparam int WORD_W = 32;
    localparam int ADDR_W = 33;
    localparam int CPU_W  = 4;
    localparam int LOG_W  = 4;
    localparam int CFG_W  = 32;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_ILINE_LOG2 = 2'd0;
    localparam logic [1:0] CFG_DLINE_LOG2 = 2'd1;
    localparam logic [1:0] CFG_NOREPEAT   = 2'd2;
    localparam logic [1:0] CFG_LIMIT      = 2'd3;

    localparam logic [LOG_W-1:0]  ILINE_RST    = 4'd6;
    localparam logic [LOG_W-1:0]  DLINE_RST    = 4'd6;
    localparam logic [LOG_W-1:0]  NOREPEAT_RST = 4'd8;
    localparam logic [CFG_W-1:0]  LIMIT_RST    = 32'd1000000;

    typedef struct packed {
        logic [CPU_W-1:0]  cpu_id;
        logic              from_cpu;
        logic              is_fetch;
        logic              is_read;
        logic [ADDR_W-1:0] byte_addr;
    } t_in_word;

    typedef struct packed {
        logic [CPU_W-1:0]  cpu_num;
        logic [WORD_W-1:0] trace_word;
        logic              end_marker;
    } t_out_word;

    typedef struct packed {
        logic capture;   // take the input word and read its CPU row
        logic commit;    // filter, update state, load the output register
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a new word this cycle
    } t_sts;

    // drop address bit 0, clear the line offset, fold in fetch and read
    function automatic logic [WORD_W-1:0] encode_word(
        input logic [ADDR_W-1:0] addr,
        input logic              fetch,
        input logic              rd,
        input logic [LOG_W-1:0]  ilog,
        input logic [LOG_W-1:0]  dlog
    );
        logic [LOG_W-1:0]  lg;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] w;
        lg   = fetch ? ilog : dlog;
        mask = ((32'd1 << lg) - 32'd1) >> 1;
        w    = addr[ADDR_W-1:1] & ~mask;
        return {w[WORD_W-1:2], w[1] | fetch, w[0] | rd};
    endfunction

endpackage

[hw/rtl/mte_ctrl.sv]
`timescale 1ns / 1ps

module mte_ctrl
    import mte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // hold until the output register has room
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/mte_dp.sv]
`timescale 1ns / 1ps

module mte_dp
    import mte_pkg::*;
#(
    parameter int NUM_CPUS     = 16,
    parameter int RECENT_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_in_word         i_in_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_data
);

    localparam int CIDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int FILL_W = $clog2(RECENT_DEPTH + 1);

    typedef logic [RECENT_DEPTH-1:0][WORD_W-1:0] t_row;

    // configuration
    logic [LOG_W-1:0] r_iline;
    logic [LOG_W-1:0] r_dline;
    logic [LOG_W-1:0] r_norep;
    logic [CFG_W-1:0] r_limit;

    // filter and trace state
    t_row              r_mem [NUM_CPUS];
    t_row              r_row;
    logic [FILL_W-1:0] r_fill [NUM_CPUS];
    logic [ADDR_W-1:0] r_count;
    logic              r_closed;
    t_in_word          r_in;
    logic              r_out_valid;
    t_out_word         r_out;

    logic              w_rd_ok;
    logic              w_cur_ok;
    logic [CIDX_W-1:0] w_rd_idx;
    logic [CIDX_W-1:0] w_cur_idx;
    logic              w_over;
    logic              w_take;
    logic [WORD_W-1:0] w_word;
    logic [FILL_W-1:0] w_fill;
    logic [FILL_W-1:0] w_depth;
    logic [FILL_W-1:0] w_fill_nx;
    logic              w_hit;
    t_row              w_new_row;
    logic              w_emit_end;
    logic              w_emit_rec;
    logic              w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iline <= ILINE_RST;
            r_dline <= DLINE_RST;
            r_norep <= NOREPEAT_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ILINE_LOG2: r_iline <= i_cfg_wdata[LOG_W-1:0];
                CFG_DLINE_LOG2: r_dline <= i_cfg_wdata[LOG_W-1:0];
                CFG_NOREPEAT:   r_norep <= i_cfg_wdata[LOG_W-1:0];
                CFG_LIMIT:      r_limit <= i_cfg_wdata;
                default:        r_limit <= r_limit;
            endcase
        end
    end

    assign w_rd_ok   = 32'(i_in_data.cpu_id) < NUM_CPUS;
    assign w_cur_ok  = 32'(r_in.cpu_id) < NUM_CPUS;
    assign w_rd_idx  = CIDX_W'(i_in_data.cpu_id);
    assign w_cur_idx = CIDX_W'(r_in.cpu_id);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
            if (w_rd_ok) begin
                r_row <= r_mem[w_rd_idx];
            end
        end
    end

    always_comb begin
        w_over  = r_count > {1'b0, r_limit};
        w_take  = !w_over && r_in.from_cpu && w_cur_ok;
        w_word  = encode_word(r_in.byte_addr, r_in.is_fetch, r_in.is_read, r_iline, r_dline);
        w_fill  = w_cur_ok ? r_fill[w_cur_idx] : '0;
        w_depth = (32'(r_norep) > RECENT_DEPTH) ? FILL_W'(RECENT_DEPTH) : FILL_W'(r_norep);
        w_hit   = 1'b0;
        for (int i = 0; i < RECENT_DEPTH; i++) begin
            if ((32'(w_fill) > i) && (r_row[i] == w_word)) begin
                w_hit = 1'b1;
            end
        end
        // push in front, oldest falls off the end
        w_new_row[0] = w_word;
        for (int i = 1; i < RECENT_DEPTH; i++) begin
            w_new_row[i] = r_row[i-1];
        end
        w_fill_nx  = (w_fill < w_depth) ? w_fill + 1'b1 : w_fill;
        w_emit_end = i_cmd.commit && w_over && !r_closed;
        w_emit_rec = i_cmd.commit && w_take && !w_hit;
        w_push     = w_emit_rec && (w_depth != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_cur_idx] <= w_new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_fill[c] <= '0;
            end
            r_count  <= '0;
            r_closed <= 1'b0;
        end else begin
            if (w_push) begin
                r_fill[w_cur_idx] <= w_fill_nx;
            end
            if (i_cmd.commit && w_take && (r_count != '1)) begin
                r_count <= r_count + 1'b1;
            end
            if (w_emit_end) begin
                r_closed <= 1'b1;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_sts.out_free) begin
            r_out_valid <= w_emit_end || w_emit_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sts.out_free) begin
            if (w_emit_end) begin
                r_out.cpu_num    <= '0;
                r_out.trace_word <= '0;
                r_out.end_marker <= 1'b1;
            end else begin
                r_out.cpu_num    <= r_in.cpu_id;
                r_out.trace_word <= w_word;
                r_out.end_marker <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/memory_trace_encoder_with_repeat_filter_top.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                   word
// -------   ---------  --------------------------  ----------------------------------
// in        input      i_in_valid / o_in_stall     t_in_word: cpu, flags, address
// out       output     o_out_valid / i_out_stall   t_out_word: cpu, trace word, end
// cfg       input      i_cfg_we                    i_cfg_addr, i_cfg_wdata
//
// An input word is first captured, and its CPU's row of recent words is read from
// the row memory; then the word is compared, the row written back and the output
// register loaded, which waits while the output register is full and stalled.
// No new input is taken until then. Reset is synchronous, active low; the row memory
// needs no clearing, the fill counts start at zero.

module memory_trace_encoder_with_repeat_filter_top
    import mte_pkg::*;
#(
    parameter int NUM_CPUS     = 16,
    parameter int RECENT_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    mte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mte_dp #(
        .NUM_CPUS     (NUM_CPUS),
        .RECENT_DEPTH (RECENT_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
